// File: src/bcdb_pkg.sv
// Shared constants, command codes and the cell command type of the dispatch balancer.
package bcdb_pkg;

  // Default sizing of the balancer.
  localparam int NUM_WORKERS_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  // Fixed field widths of the stream words.
  localparam int WORKER_W   = 4;
  localparam int AMOUNT_W   = 16;
  localparam int RECIP_W    = 4;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  // Opcode carried in in_tuser.
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_GET = 1'b1;

  // Commands broadcast to every cell.
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_SUB  = 2'd2;
  localparam logic [1:0] CMD_DEC  = 2'd3;

  typedef struct packed {
    logic [1:0] op;        // counter update applied this cycle
    logic       scan_max;  // 1: scan looks for the largest counter, 0: the smallest
  } cell_cmd_t;

endpackage

// File: src/bcdb_cell.sv
// One counter cell of the balancer chain, with its stage of the min/max scan.
module bcdb_cell #(
  parameter int COUNT_WIDTH = bcdb_pkg::COUNT_WIDTH_DEF,
  parameter int IDX_W       = 3,
  parameter int CELL_IDX    = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bcdb_pkg::cell_cmd_t           cmd,
  input  logic [IDX_W-1:0]              tgt_idx,
  input  logic [bcdb_pkg::AMOUNT_W-1:0] add_amount,
  input  logic [COUNT_WIDTH-1:0]        sub_val,
  input  logic                          tok_in,
  input  logic [COUNT_WIDTH-1:0]        part_in_val,
  input  logic [IDX_W-1:0]              part_in_idx,
  input  logic                          part_in_nz,
  output logic                          tok_out,
  output logic [COUNT_WIDTH-1:0]        part_out_val,
  output logic [IDX_W-1:0]              part_out_idx,
  output logic                          part_out_nz
);
  import bcdb_pkg::*;

  localparam int SUM_W = ((COUNT_WIDTH > AMOUNT_W) ? COUNT_WIDTH : AMOUNT_W) + 1;

  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   tok_r;
  logic [COUNT_WIDTH-1:0] pval_r, pval_nxt;
  logic [IDX_W-1:0]       pidx_r, pidx_nxt;
  logic                   pnz_r;
  logic                   is_tgt;
  logic [SUM_W-1:0]       sum;
  logic [COUNT_WIDTH-1:0] sat_sum;
  logic                   take;

  assign is_tgt  = (tgt_idx == IDX_W'(CELL_IDX));
  assign sum     = SUM_W'(cnt_r) + SUM_W'(add_amount);
  // Anything above the counter width means the sum saturates.
  assign sat_sum = (|sum[SUM_W-1:COUNT_WIDTH]) ? '1 : sum[COUNT_WIDTH-1:0];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case (cmd.op)
      CMD_ADD: begin
        if (is_tgt) begin
          cnt_nxt = sat_sum;
        end
      end
      CMD_SUB: begin
        cnt_nxt = cnt_r - sub_val;
      end
      CMD_DEC: begin
        if (is_tgt) begin
          cnt_nxt = cnt_r - COUNT_WIDTH'(1);
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // Strict compares keep the lowest index on a tie, since the scan runs upward.
  always_comb begin
    take     = cmd.scan_max ? (cnt_r > part_in_val) : (cnt_r < part_in_val);
    pval_nxt = take ? cnt_r : part_in_val;
    pidx_nxt = take ? IDX_W'(CELL_IDX) : part_in_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      tok_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) begin
      pval_r <= pval_nxt;
      pidx_r <= pidx_nxt;
      pnz_r  <= part_in_nz & (cnt_r != '0);
    end
  end

  assign tok_out      = tok_r;
  assign part_out_val = pval_r;
  assign part_out_idx = pidx_r;
  assign part_out_nz  = pnz_r;

endmodule

// File: src/backlog_credit_dispatch_balancer.sv
// Top level of the backlog credit dispatch balancer: sequencer and chain of counter cells.
//
//  Channel | Ports      | Word contents (lowest bit first)
//  --------+------------+-----------------------------------------------------
//  input   | in_tdata   | worker[3:0], amount[19:4], zero pad[23:20]
//          | in_tuser   | opcode[0] (0 = add, 1 = get)
//  output  | out_tdata  | recipient[3:0], zero pad[7:4]; one word per get
//
// An add word passes through update, scan start, the scan token's walk through the
// chain one cell after another, level-down, and the idle state that takes the next
// word; a get word skips the update and may also wait for the output register to
// drain. An add with an out-of-range worker leaves the sequencer idle. The serial
// walk through the chain of cells sets the length of each pass. Reset (synchronous,
// active low) clears all counters; a new input word is taken while a result still
// waits on out_.
module backlog_credit_dispatch_balancer #(
  parameter int NUM_WORKERS = bcdb_pkg::NUM_WORKERS_DEF,
  parameter int COUNT_WIDTH = bcdb_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bcdb_pkg::IN_DATA_W-1:0]  in_tdata,   // worker, amount
  input  logic [0:0]                      in_tuser,   // opcode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bcdb_pkg::OUT_DATA_W-1:0] out_tdata   // recipient
);
  import bcdb_pkg::*;

  localparam int IDX_W = $clog2(NUM_WORKERS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_ACT   = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic                is_get_r;
  logic [IDX_W-1:0]    tgt_r;
  logic [AMOUNT_W-1:0] amount_r;
  logic                out_tvalid_r;
  logic [RECIP_W-1:0]  out_rcp_r;

  logic [WORKER_W-1:0] in_worker;
  logic                in_acc;
  logic                worker_ok;
  logic                out_free;
  logic                load_out;

  cell_cmd_t           cmd;
  logic [IDX_W-1:0]    cell_tgt;

  // Scan chain: index 0 is the seed from the sequencer, index NUM_WORKERS the result.
  logic                   tok  [0:NUM_WORKERS];
  logic [COUNT_WIDTH-1:0] pval [0:NUM_WORKERS];
  logic [IDX_W-1:0]       pidx [0:NUM_WORKERS];
  logic                   pnz  [0:NUM_WORKERS];

  assign in_worker = in_tdata[WORKER_W-1:0];
  assign in_acc    = in_tvalid & in_tready;
  assign in_tready = (state_r == ST_IDLE);
  // Worker numbers run from 1; anything else makes the add a no-op.
  assign worker_ok = (in_worker != '0) && (32'(in_worker) <= 32'(NUM_WORKERS));
  assign out_free  = !out_tvalid_r || out_tready;
  assign load_out  = (state_r == ST_ACT) && is_get_r && out_free;

  // A min scan starts from the counter maximum with every counter assumed
  // nonzero; a max scan starts from zero at worker 1.
  assign tok[0]  = (state_r == ST_START);
  assign pval[0] = is_get_r ? '0 : '1;
  assign pidx[0] = '0;
  assign pnz[0]  = 1'b1;

  always_comb begin
    cmd.op       = CMD_NONE;
    cmd.scan_max = is_get_r;
    if (state_r == ST_ADD) begin
      cmd.op = CMD_ADD;
    end else if (state_r == ST_ACT) begin
      if (!is_get_r) begin
        // Every counter nonzero after the add: level all of them down by the minimum.
        if (pnz[NUM_WORKERS]) begin
          cmd.op = CMD_SUB;
        end
      end else if (out_free && (pval[NUM_WORKERS] != '0)) begin
        cmd.op = CMD_DEC;
      end
    end
  end

  assign cell_tgt = (state_r == ST_ACT) ? pidx[NUM_WORKERS] : tgt_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == OP_GET) begin
            state_nxt = ST_START;
          end else if (worker_ok) begin
            state_nxt = ST_ADD;
          end
        end
      end
      ST_ADD: begin
        state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (tok[NUM_WORKERS]) begin
          state_nxt = ST_ACT;
        end
      end
      ST_ACT: begin
        if (!is_get_r || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      is_get_r <= (in_tuser[0] == OP_GET);
      tgt_r    <= IDX_W'(32'(in_worker) - 32'd1);
      amount_r <= in_tdata[WORKER_W +: AMOUNT_W];
    end
    if (load_out) begin
      out_rcp_r <= RECIP_W'(32'(pidx[NUM_WORKERS]) + 32'd1);
    end
  end

  for (genvar k = 0; k < NUM_WORKERS; k++) begin : g_cell
    bcdb_cell #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .IDX_W       (IDX_W),
      .CELL_IDX    (k)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cmd),
      .tgt_idx      (cell_tgt),
      .add_amount   (amount_r),
      .sub_val      (pval[NUM_WORKERS]),
      .tok_in       (tok[k]),
      .part_in_val  (pval[k]),
      .part_in_idx  (pidx[k]),
      .part_in_nz   (pnz[k]),
      .tok_out      (tok[k+1]),
      .part_out_val (pval[k+1]),
      .part_out_idx (pidx[k+1]),
      .part_out_nz  (pnz[k+1])
    );
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W - RECIP_W){1'b0}}, out_rcp_r};

endmodule

// File: src/bcdb_checker.sv
// Port-level checker of the dispatch balancer, bound to the top level.
module bcdb_checker #(
  parameter int NUM_WORKERS = bcdb_pkg::NUM_WORKERS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [0:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bcdb_pkg::OUT_DATA_W-1:0] out_tdata
);
  import bcdb_pkg::*;

  // A result waiting on a stalled output keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // Recipients are legal worker numbers with a zero pad.
  a_rcp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_DATA_W-1:RECIP_W] == '0) &&
                   ((NUM_WORKERS > 15) ||
                    ((out_tdata[RECIP_W-1:0] != '0) &&
                     (32'(out_tdata[RECIP_W-1:0]) <= 32'(NUM_WORKERS)))))
    else $error("recipient out of range");

  // A get keeps the block busy while it scans the chain.
  a_get_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == OP_GET) |=> !in_tready)
    else $error("input taken right after a get");

  // A new result is only produced while the block is busy.
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without work in progress");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind backlog_credit_dispatch_balancer bcdb_checker #(
  .NUM_WORKERS (NUM_WORKERS)
) u_bcdb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: bench/bcdb_checker.sv
// Channel monitor, backlog predictor and result comparator of the dispatch balancer bench.
module bcdb_scoreboard (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bcdb_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [0:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [bcdb_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              pending,
  output int                              leveling_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NW = bcdb_pkg::NUM_WORKERS_DEF;
  localparam int CW = bcdb_pkg::COUNT_WIDTH_DEF;
  localparam logic [63:0] COUNT_MAX = (64'd1 << CW) - 64'd1;

  logic [CW-1:0]                backlog [NW];
  int                           zero_slots;
  logic [bcdb_pkg::RECIP_W-1:0] recipient_q[$];

  // Subtract the smallest counter from all of them once none is zero.
  task automatic level_down();
    logic [CW-1:0] least;
    least = COUNT_MAX[CW-1:0];
    for (int k = 0; k < NW; k++) begin
      if (backlog[k] < least) least = backlog[k];
    end
    for (int k = 0; k < NW; k++) begin
      backlog[k] = backlog[k] - least;
      if (backlog[k] == '0) zero_slots++;
    end
    leveling_count++;
  endtask

  // Update the backlog for one accepted word and queue the recipient of a get.
  task automatic apply_word(input logic op, input logic [bcdb_pkg::WORKER_W-1:0] wk,
                            input logic [bcdb_pkg::AMOUNT_W-1:0] amt);
    logic [63:0] total;
    logic [CW-1:0] best;
    int pick;
    if (op == bcdb_pkg::OP_ADD) begin
      if (wk >= 1 && wk <= NW) begin
        total = 64'(backlog[wk-1]) + 64'(amt);
        if (total > COUNT_MAX) total = COUNT_MAX;
        if (backlog[wk-1] == '0 && total != 0) zero_slots--;
        backlog[wk-1] = total[CW-1:0];
        if (zero_slots == 0) level_down();
      end
    end else begin
      best = '0;
      pick = 0;
      for (int k = 0; k < NW; k++) begin
        if (backlog[k] > best) begin
          best = backlog[k];
          pick = k;
        end
      end
      if (backlog[pick] != '0) begin
        backlog[pick] = backlog[pick] - 1'b1;
        if (backlog[pick] == '0) zero_slots++;
      end
      recipient_q.push_back(bcdb_pkg::RECIP_W'(pick + 1));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NW; k++) backlog[k] = '0;
      zero_slots = NW;
      recipient_q.delete();
      fail_count = 0;
      leveling_count = 0;
    end else begin
      // Results belong to words accepted at earlier edges, so compare first.
      if (out_tvalid && out_tready) begin
        if (recipient_q.size() == 0) begin
          if (fail_count < 10)
            $display("[%0t] unexpected result word 0x%02h", $realtime, out_tdata);
          fail_count++;
        end else begin
          logic [bcdb_pkg::RECIP_W-1:0] want;
          want = recipient_q.pop_front();
          if (out_tdata[bcdb_pkg::RECIP_W-1:0] !== want ||
              out_tdata[bcdb_pkg::OUT_DATA_W-1:bcdb_pkg::RECIP_W] !== '0) begin
            if (fail_count < 10)
              $display("[%0t] recipient mismatch: expected %0d, got %0d (word 0x%02h)",
                       $realtime, want, out_tdata[bcdb_pkg::RECIP_W-1:0], out_tdata);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        apply_word(in_tuser[0], in_tdata[bcdb_pkg::WORKER_W-1:0],
                   in_tdata[bcdb_pkg::WORKER_W +: bcdb_pkg::AMOUNT_W]);
    end
    pending = recipient_q.size();
  end

endmodule

// File: bench/tb_backlog_credit_dispatch_balancer.sv
// Top of the dispatch balancer bench: clock, reset, stimulus, output stalls and verdict.
module tb_backlog_credit_dispatch_balancer;
  timeunit 1ns;
  timeprecision 1ps;

  import bcdb_pkg::*;

  localparam int NW          = NUM_WORKERS_DEF;
  localparam int PHASE_WORDS = 125;   // four phases make about 500 random words
  localparam int HOLD_CYCLES = 300;   // long output hold-off that backs up the input
  localparam int QUIET_LIMIT = 3000;  // cycles with no handshake before giving up
  localparam int TAIL_CYCLES = 40;    // well beyond the pass of one word through the block

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [0:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int pending;
  int leveling_count;

  // Receiver controls; the stimulus process writes stall_pct and hold_requests with nonblocking assignments.
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  // Word tallies for the closing summary.
  int n_add     = 0;
  int n_get     = 0;
  int n_ignored = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  backlog_credit_dispatch_balancer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  bcdb_scoreboard u_scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .fail_count     (fail_count),
    .pending        (pending),
    .leveling_count (leveling_count)
  );

  // Receiver: random stalls at the current rate, and a long hold-off whenever the
  // stimulus asks for one. The hold-off is counted here, independent of the sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_tready  <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: ends the run when no word moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("no word moved for %0d cycles", QUIET_LIMIT);
    $display("backlog_credit_dispatch_balancer regression: fail");
    $finish;
  end

  initial begin : stimulus
    int idle_pct;
    int sent;
    int start;
    idle_pct = 0;
    sent = 0;
    start = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words. Gets on an empty backlog must answer worker 1 and change nothing.
    send_word(OP_GET, 4'd1, 16'h0000);
    send_word(OP_ADD, 4'd1, 16'h0000);   // zero amount leaves worker 1 at zero
    send_word(OP_GET, 4'd0, 16'hFFFF);
    // Out-of-range workers are dropped silently.
    send_word(OP_ADD, 4'd0, 16'h0005);
    send_word(OP_ADD, 4'd9, 16'hFFFF);
    send_word(OP_ADD, 4'd15, 16'hAAAA);
    send_word(OP_GET, 4'd15, 16'h0000);
    // Worker 3 saturates at the counter maximum.
    send_word(OP_ADD, 4'd3, 16'hFFFF);
    send_word(OP_ADD, 4'd3, 16'h5555);
    send_word(OP_GET, 4'd3, 16'h0000);
    // Fill the rest so every counter is nonzero and the minimum is leveled off.
    send_word(OP_ADD, 4'd8, 16'h0001);
    send_word(OP_ADD, 4'd1, 16'h0002);
    send_word(OP_ADD, 4'd2, 16'h0004);
    send_word(OP_ADD, 4'd4, 16'h0006);
    send_word(OP_ADD, 4'd5, 16'h8000);
    send_word(OP_ADD, 4'd6, 16'h0008);
    send_word(OP_ADD, 4'd7, 16'h0003);
    send_word(OP_GET, 4'd2, 16'h1234);
    send_word(OP_GET, 4'd0, 16'h0000);
    send_word(OP_GET, 4'd9, 16'h0000);
    send_word(OP_ADD, 4'd2, 16'h0000);
    send_word(OP_ADD, 4'd5, 16'h7FFF);
    send_word(OP_GET, 4'd8, 16'h0000);
    in_tvalid <= 1'b0;
    drain();

    // Random phases: free flow, idle sender, stalling receiver, and both at once.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 60; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 60; end
        default: begin idle_pct = 26; stall_pct <= 26; end
      endcase
      sent = 0;
      while (sent < PHASE_WORDS) begin
        // During free flow, hold the receiver off for a long stretch so results
        // back up and the block has to stall its input.
        if (phase == 0 && sent >= 20 && hold_requests == 0) hold_requests <= 1;
        if ($urandom_range(99) < 12) begin
          // Well-formed fill: an add to every worker, which tends to level down.
          start = $urandom_range(NW - 1);
          for (int k = 0; k < NW; k++)
            send_word(OP_ADD, WORKER_W'((start + k) % NW + 1),
                      AMOUNT_W'($urandom_range(5, 1)), idle_pct);
          sent += NW;
        end else begin
          send_random_word(idle_pct);
          sent++;
        end
      end
      in_tvalid <= 1'b0;
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d add words (%0d to absent workers), %0d get words, %0d level-downs,",
             n_add, n_ignored, n_get, leveling_count);
    $display("under free flow, sender gaps, receiver stalls, both, and a long output hold.");
    if (fail_count == 0 && pending == 0) begin
      $display("backlog_credit_dispatch_balancer regression: pass");
    end else begin
      $display("backlog_credit_dispatch_balancer regression: fail");
    end
    $finish;
  end

  // Offer one word, possibly after a random gap, and return at the edge that takes it.
  task automatic send_word(input logic op, input logic [WORKER_W-1:0] wk,
                           input logic [AMOUNT_W-1:0] amt, input int idle_pct = 0);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - WORKER_W - AMOUNT_W){1'b0}}, amt, wk};
    do @(posedge clk); while (!in_tready);
    if (op == OP_GET) begin
      n_get++;
    end else begin
      n_add++;
      if (wk < 1 || wk > NW) n_ignored++;
    end
  endtask

  // Mostly small amounts so gets drain counters back to zero, with some large
  // and saturating ones; a few adds name workers that do not exist.
  task automatic send_random_word(input int idle_pct);
    logic                op;
    logic [WORKER_W-1:0] wk;
    logic [AMOUNT_W-1:0] amt;
    int                  sel;
    op = ($urandom_range(99) < 40) ? OP_GET : OP_ADD;
    if ($urandom_range(99) < 88) wk = WORKER_W'($urandom_range(NW, 1));
    else if ($urandom_range(1) == 0) wk = '0;
    else wk = WORKER_W'($urandom_range((1 << WORKER_W) - 1, NW + 1));
    sel = $urandom_range(99);
    if (sel < 45) amt = AMOUNT_W'($urandom_range(3, 1));
    else if (sel < 65) amt = AMOUNT_W'($urandom_range(15));
    else if (sel < 70) amt = '0;
    else if (sel < 82) amt = AMOUNT_W'($urandom_range((1 << AMOUNT_W) - 1, 16'hFF00));
    else amt = AMOUNT_W'($urandom());
    send_word(op, wk, amt, idle_pct);
  endtask

  // Wait until every expected recipient has come back. The first edge lets the
  // checker record the last word taken before any count is looked at.
  task automatic drain();
    do @(posedge clk); while (pending != 0);
  endtask

endmodule
